>>> sv/ossc_pkg.sv
package ossc_pkg;

  // Position and arithmetic widths
  localparam int POS_W   = 24;
  localparam int DIFF_W  = POS_W + 1;
  localparam int TH_W    = 13;
  localparam int OFS_W   = 14;
  localparam int STEP_W  = 8;
  localparam int RAD_W   = 11;
  localparam int HOLD_W  = 8;
  localparam int FLAG_W  = 4;
  localparam int CNT_W   = 7;
  localparam int PHASE_W = 3;

  // Configuration port
  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;
  localparam int IDX_W   = 3;

  // Register limits and reset values
  localparam int TH_MIN   = 1500;
  localparam int TH_MAX   = 5000;
  localparam int TH_RST   = 3000;
  localparam int OFS_MIN  = -5000;
  localparam int OFS_MAX  = 5000;
  localparam int OFSX_RST = 3000;
  localparam int OFSY_RST = 0;
  localparam int STEP_MIN = 25;
  localparam int STEP_MAX = 150;
  localparam int STEP_RST = 75;
  localparam int RAD_MIN  = 300;
  localparam int RAD_MAX  = 2000;
  localparam int RAD_RST  = 800;
  localparam int HOLD_MIN = 10;
  localparam int HOLD_MAX = 200;
  localparam int HOLD_RST = 40;
  localparam int FLAG_RST = 12;

  // Sequencer constants
  localparam int CNT_SAT   = 81;
  localparam int OFF_AFTER = 40;
  localparam int ARM_AFTER = 80;
  localparam int CMD_Z_RST = -3000;

  // Mode flag bit positions
  localparam int FLAG_AUTO_OFF = 0;
  localparam int FLAG_AUTO_ARM = 1;
  localparam int FLAG_REQ_OFF  = 2;
  localparam int FLAG_REQ_ARM  = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_TARGET_HEIGHT = 3'd0,
    REG_OUT_OFFSET_X  = 3'd1,
    REG_OUT_OFFSET_Y  = 3'd2,
    REG_XY_STEP       = 3'd3,
    REG_Z_STEP        = 3'd4,
    REG_REACH_RADIUS  = 3'd5,
    REG_HOLD_TICKS    = 3'd6,
    REG_MODE_FLAGS    = 3'd7
  } reg_idx_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_WAIT      = 3'd0,
    PH_GO_OUT    = 3'd1,
    PH_HOLD_OUT  = 3'd2,
    PH_RETURN    = 3'd3,
    PH_HOLD_HOME = 3'd4,
    PH_DONE      = 3'd5
  } phase_t;

  typedef struct packed {
    logic [TH_W-1:0]         target_height;
    logic signed [OFS_W-1:0] out_offset_x;
    logic signed [OFS_W-1:0] out_offset_y;
    logic [STEP_W-1:0]       xy_step;
    logic [STEP_W-1:0]       z_step;
    logic [RAD_W-1:0]        reach_radius;
    logic [HOLD_W-1:0]       hold_ticks;
    logic [FLAG_W-1:0]       mode_flags;
  } cfg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    position_healthy;
    logic                    status_known;
    logic                    in_offboard;
    logic                    is_armed;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] setpoint_x;
    logic signed [POS_W-1:0] setpoint_y;
    logic signed [POS_W-1:0] setpoint_z;
    logic                    setpoint_valid;
    logic                    request_offboard;
    logic                    request_arm;
    logic [PHASE_W-1:0]      mission_phase;
  } out_item_t;

endpackage

>>> sv/out_and_back_setpoint_sequencer_core.sv
// Flow: an accepted request waits in the input register, then passes through
//   the sequencer logic into the result register, where it waits to be taken.
// Throughput: one request per cycle unless out_stall holds the result, limited
//   by the single sequencer pass between the input and result registers.
// Reset (rst_n low, synchronous): both registers empty, sequencer in wait with
//   home unlatched, configuration registers back to their reset values.
module out_and_back_setpoint_sequencer_core
  import ossc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,

  // Input request channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  input  logic signed [POS_W-1:0] in_pos_z,
  input  logic                    in_position_healthy,
  input  logic                    in_status_known,
  input  logic                    in_in_offboard,
  input  logic                    in_is_armed,

  // Result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [POS_W-1:0] out_setpoint_x,
  output logic signed [POS_W-1:0] out_setpoint_y,
  output logic signed [POS_W-1:0] out_setpoint_z,
  output logic                    out_setpoint_valid,
  output logic                    out_request_offboard,
  output logic                    out_request_arm,
  output logic [PHASE_W-1:0]      out_mission_phase,

  // Configuration port
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [CFG_AW-1:0]       cfg_paddr,
  input  logic [CFG_DW-1:0]       cfg_pwdata,
  output logic [CFG_DW-1:0]       cfg_prdata,
  output logic                    cfg_pready
);

  cfg_t      cfg;
  in_item_t  in_item_r;
  logic      in_vld_r, in_vld_nxt;
  out_item_t res;
  out_item_t out_item_r;
  logic      out_vld_r, out_vld_nxt;
  logic      accept, advance;

  // Register bank with write saturation
  ossc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // The input register moves into the sequencer whenever the result register
  // is empty or is being drained this cycle. Stall the input side only when
  // both registers are full and the result is itself stalled, so a new
  // request still lands while a finished result waits to be taken.
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && out_vld_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (accept) in_vld_nxt = 1'b1;
    else if (advance) in_vld_nxt = 1'b0;
  end

  // Result stays while stalled; a new one loads as the input register advances
  assign out_vld_nxt = advance || (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers: no reset, load on handshake
  always_ff @(posedge clk) begin
    if (accept) begin
      in_item_r.pos_x            <= in_pos_x;
      in_item_r.pos_y            <= in_pos_y;
      in_item_r.pos_z            <= in_pos_z;
      in_item_r.position_healthy <= in_position_healthy;
      in_item_r.status_known     <= in_status_known;
      in_item_r.in_offboard      <= in_in_offboard;
      in_item_r.is_armed         <= in_is_armed;
    end
    if (advance) begin
      out_item_r <= res;
    end
  end

  // Sequencer state advances exactly once per request that moves on
  ossc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_valid            = out_vld_r;
  assign out_setpoint_x       = out_item_r.setpoint_x;
  assign out_setpoint_y       = out_item_r.setpoint_y;
  assign out_setpoint_z       = out_item_r.setpoint_z;
  assign out_setpoint_valid   = out_item_r.setpoint_valid;
  assign out_request_offboard = out_item_r.request_offboard;
  assign out_request_arm      = out_item_r.request_arm;
  assign out_mission_phase    = out_item_r.mission_phase;

endmodule

>>> sv/ossc_cfg.sv
module ossc_cfg
  import ossc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  logic     wr_en;
  reg_idx_t idx;

  function automatic logic [15:0] clamp_u(input logic [15:0] v, input int lo, input int hi);
    logic [15:0] res;
    res = v;
    if (v < 16'(lo)) res = 16'(lo);
    else if (v > 16'(hi)) res = 16'(hi);
    return res;
  endfunction

  function automatic logic signed [OFS_W-1:0] clamp_ofs(input logic signed [OFS_W-1:0] v);
    logic signed [OFS_W-1:0] res;
    res = v;
    if (v < $signed(OFS_W'(OFS_MIN))) res = $signed(OFS_W'(OFS_MIN));
    else if (v > $signed(OFS_W'(OFS_MAX))) res = $signed(OFS_W'(OFS_MAX));
    return res;
  endfunction

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = reg_idx_t'(cfg_paddr[IDX_W+1:2]);

  // Saturate each write to its register's range; mode flags are written as given
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_TARGET_HEIGHT: cfg_nxt.target_height =
          TH_W'(clamp_u(16'(cfg_pwdata[TH_W-1:0]), TH_MIN, TH_MAX));
        REG_OUT_OFFSET_X:  cfg_nxt.out_offset_x = clamp_ofs($signed(cfg_pwdata[OFS_W-1:0]));
        REG_OUT_OFFSET_Y:  cfg_nxt.out_offset_y = clamp_ofs($signed(cfg_pwdata[OFS_W-1:0]));
        REG_XY_STEP:       cfg_nxt.xy_step =
          STEP_W'(clamp_u(16'(cfg_pwdata[STEP_W-1:0]), STEP_MIN, STEP_MAX));
        REG_Z_STEP:        cfg_nxt.z_step =
          STEP_W'(clamp_u(16'(cfg_pwdata[STEP_W-1:0]), STEP_MIN, STEP_MAX));
        REG_REACH_RADIUS:  cfg_nxt.reach_radius =
          RAD_W'(clamp_u(16'(cfg_pwdata[RAD_W-1:0]), RAD_MIN, RAD_MAX));
        REG_HOLD_TICKS:    cfg_nxt.hold_ticks =
          HOLD_W'(clamp_u(16'(cfg_pwdata[HOLD_W-1:0]), HOLD_MIN, HOLD_MAX));
        REG_MODE_FLAGS:    cfg_nxt.mode_flags = cfg_pwdata[FLAG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_height <= TH_W'(TH_RST);
      cfg_r.out_offset_x  <= $signed(OFS_W'(OFSX_RST));
      cfg_r.out_offset_y  <= $signed(OFS_W'(OFSY_RST));
      cfg_r.xy_step       <= STEP_W'(STEP_RST);
      cfg_r.z_step        <= STEP_W'(STEP_RST);
      cfg_r.reach_radius  <= RAD_W'(RAD_RST);
      cfg_r.hold_ticks    <= HOLD_W'(HOLD_RST);
      cfg_r.mode_flags    <= FLAG_W'(FLAG_RST);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_TARGET_HEIGHT: cfg_prdata = CFG_DW'(cfg_r.target_height);
      REG_OUT_OFFSET_X:  cfg_prdata = CFG_DW'($signed(cfg_r.out_offset_x));
      REG_OUT_OFFSET_Y:  cfg_prdata = CFG_DW'($signed(cfg_r.out_offset_y));
      REG_XY_STEP:       cfg_prdata = CFG_DW'(cfg_r.xy_step);
      REG_Z_STEP:        cfg_prdata = CFG_DW'(cfg_r.z_step);
      REG_REACH_RADIUS:  cfg_prdata = CFG_DW'(cfg_r.reach_radius);
      REG_HOLD_TICKS:    cfg_prdata = CFG_DW'(cfg_r.hold_ticks);
      REG_MODE_FLAGS:    cfg_prdata = CFG_DW'(cfg_r.mode_flags);
      default:           cfg_prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

>>> sv/ossc_reach.sv
module ossc_reach
  import ossc_pkg::*;
(
  input  logic signed [POS_W-1:0] px,
  input  logic signed [POS_W-1:0] py,
  input  logic signed [POS_W-1:0] pz,
  input  logic signed [POS_W-1:0] tx,
  input  logic signed [POS_W-1:0] ty,
  input  logic signed [POS_W-1:0] tz,
  input  logic [RAD_W-1:0]        radius,
  output logic                    reached
);

  localparam int SQ_W  = RAD_W + 1;
  localparam int PR_W  = 2 * SQ_W;
  localparam int MAG_W = 2 * RAD_W;
  localparam int SUM_W = MAG_W + 2;

  logic signed [DIFF_W-1:0] dx, dy, dz, rs;
  logic                     in_box;
  logic signed [SQ_W-1:0]   dx_n, dy_n, dz_n;
  logic signed [PR_W-1:0]   sq_x, sq_y, sq_z;
  logic [SUM_W-1:0]         sum;
  logic [MAG_W-1:0]         r2;

  assign dx = DIFF_W'(px) - DIFF_W'(tx);
  assign dy = DIFF_W'(py) - DIFF_W'(ty);
  assign dz = DIFF_W'(pz) - DIFF_W'(tz);
  assign rs = $signed({{(DIFF_W-RAD_W){1'b0}}, radius});

  // Box test first; inside it every difference fits the narrow squarers
  assign in_box = (dx <= rs) && (dx >= -rs) && (dy <= rs) && (dy >= -rs) &&
                  (dz <= rs) && (dz >= -rs);

  assign dx_n = dx[SQ_W-1:0];
  assign dy_n = dy[SQ_W-1:0];
  assign dz_n = dz[SQ_W-1:0];

  assign sq_x = dx_n * dx_n;
  assign sq_y = dy_n * dy_n;
  assign sq_z = dz_n * dz_n;

  assign sum = SUM_W'(sq_x[MAG_W-1:0]) + SUM_W'(sq_y[MAG_W-1:0]) + SUM_W'(sq_z[MAG_W-1:0]);
  assign r2  = MAG_W'(radius) * MAG_W'(radius);

  assign reached = in_box && (sum <= SUM_W'(r2));

endmodule

>>> sv/ossc_seq.sv
module ossc_seq
  import ossc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t res
);

  phase_t                  phase_r, phase_nxt;
  logic signed [POS_W-1:0] home_x_r, home_y_r, out_x_r, out_y_r;
  logic signed [POS_W-1:0] cmd_x_r, cmd_y_r, cmd_z_r;
  logic signed [POS_W-1:0] cmd_x_nxt, cmd_y_nxt, cmd_z_nxt;
  logic                    home_latched_r, offboard_sent_r, arm_sent_r, hold_active_r;
  logic                    hold_active_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [HOLD_W-1:0]       hold_count_r, hold_count_nxt, hold_inc;

  logic                    healthy, latch, ready, hold_done, reached, at_out;
  logic                    req_off, req_arm, off_sent_now;
  logic signed [POS_W-1:0] tz, home_x_l, home_y_l, out_x_l, out_y_l;
  logic signed [POS_W-1:0] cmd_x_l, cmd_y_l, cmd_z_l, goal_x, goal_y;
  logic signed [POS_W-1:0] stp_x, stp_y, stp_z;

  function automatic logic signed [POS_W-1:0] step_toward(
    input logic signed [POS_W-1:0] cur,
    input logic signed [POS_W-1:0] tgt,
    input logic [STEP_W-1:0]       stp
  );
    logic signed [DIFF_W-1:0] d, s, mv;
    d  = DIFF_W'(tgt) - DIFF_W'(cur);
    s  = $signed({{(DIFF_W-STEP_W){1'b0}}, stp});
    mv = (d > 0) ? DIFF_W'(cur) + s : DIFF_W'(cur) - s;
    if (d <= s && d >= -s) return tgt;
    return mv[POS_W-1:0];
  endfunction

  function automatic logic signed [POS_W-1:0] sat_add(
    input logic signed [POS_W-1:0] pos,
    input logic signed [OFS_W-1:0] ofs
  );
    logic signed [DIFF_W-1:0] s;
    s = DIFF_W'(pos) + DIFF_W'(ofs);
    if (s[DIFF_W-1] != s[DIFF_W-2])
      return s[DIFF_W-1] ? $signed({1'b1, {(POS_W-1){1'b0}}})
                         : $signed({1'b0, {(POS_W-1){1'b1}}});
    return s[POS_W-1:0];
  endfunction

  assign healthy  = item.position_healthy;
  assign latch    = healthy && !home_latched_r;
  assign tz       = -$signed({{(POS_W-TH_W){1'b0}}, cfg.target_height});

  // Home and out point as seen after this tick's latch
  assign home_x_l = latch ? item.pos_x : home_x_r;
  assign home_y_l = latch ? item.pos_y : home_y_r;
  assign out_x_l  = latch ? sat_add(item.pos_x, cfg.out_offset_x) : out_x_r;
  assign out_y_l  = latch ? sat_add(item.pos_y, cfg.out_offset_y) : out_y_r;
  assign cmd_x_l  = latch ? item.pos_x : cmd_x_r;
  assign cmd_y_l  = latch ? item.pos_y : cmd_y_r;
  assign cmd_z_l  = latch ? tz : cmd_z_r;

  assign hold_inc = (hold_active_r && hold_count_r != '1) ? hold_count_r + 1'b1 : hold_count_r;

  assign cnt_nxt      = (healthy && cnt_r < CNT_W'(CNT_SAT)) ? cnt_r + 1'b1 : cnt_r;
  assign req_off      = healthy && cfg.mode_flags[FLAG_AUTO_OFF] && !offboard_sent_r &&
                        (cnt_nxt > CNT_W'(OFF_AFTER));
  assign off_sent_now = offboard_sent_r || req_off;
  assign req_arm      = healthy && cfg.mode_flags[FLAG_AUTO_ARM] && off_sent_now &&
                        !arm_sent_r && (cnt_nxt > CNT_W'(ARM_AFTER));

  assign ready = healthy && item.status_known &&
                 (!cfg.mode_flags[FLAG_REQ_OFF] || item.in_offboard) &&
                 (!cfg.mode_flags[FLAG_REQ_ARM] || item.is_armed);

  assign at_out    = (phase_r == PH_GO_OUT) || (phase_r == PH_HOLD_OUT);
  assign goal_x    = at_out ? out_x_l : home_x_l;
  assign goal_y    = at_out ? out_y_l : home_y_l;
  assign hold_done = hold_active_r && (hold_inc >= cfg.hold_ticks);

  assign stp_x = step_toward(cmd_x_l, goal_x, cfg.xy_step);
  assign stp_y = step_toward(cmd_y_l, goal_y, cfg.xy_step);
  assign stp_z = step_toward(cmd_z_l, tz, cfg.z_step);

  ossc_reach u_reach (
    .px      (item.pos_x),
    .py      (item.pos_y),
    .pz      (item.pos_z),
    .tx      (goal_x),
    .ty      (goal_y),
    .tz      (tz),
    .radius  (cfg.reach_radius),
    .reached (reached)
  );

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (ready) begin
      case (phase_r)
        PH_WAIT:      phase_nxt = PH_GO_OUT;
        PH_GO_OUT:    if (reached) phase_nxt = PH_HOLD_OUT;
        PH_HOLD_OUT:  if (hold_done) phase_nxt = PH_RETURN;
        PH_RETURN:    if (reached) phase_nxt = PH_HOLD_HOME;
        PH_HOLD_HOME: if (hold_done) phase_nxt = PH_DONE;
        default:      phase_nxt = PH_DONE;
      endcase
    end
  end

  // Setpoint and hold bookkeeping per phase
  always_comb begin
    cmd_x_nxt       = cmd_x_l;
    cmd_y_nxt       = cmd_y_l;
    cmd_z_nxt       = cmd_z_l;
    hold_active_nxt = hold_active_r;
    hold_count_nxt  = hold_inc;
    if (ready) begin
      case (phase_r)
        PH_WAIT: ;
        PH_GO_OUT, PH_RETURN: begin
          if (reached) begin
            cmd_x_nxt       = goal_x;
            cmd_y_nxt       = goal_y;
            cmd_z_nxt       = tz;
            hold_count_nxt  = '0;
            hold_active_nxt = 1'b1;
          end else begin
            cmd_x_nxt = stp_x;
            cmd_y_nxt = stp_y;
            cmd_z_nxt = stp_z;
          end
        end
        default: begin
          cmd_x_nxt = goal_x;
          cmd_y_nxt = goal_y;
          cmd_z_nxt = tz;
          if (hold_done) hold_active_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_WAIT;
      home_x_r        <= '0;
      home_y_r        <= '0;
      out_x_r         <= '0;
      out_y_r         <= '0;
      cmd_x_r         <= '0;
      cmd_y_r         <= '0;
      cmd_z_r         <= $signed(POS_W'(CMD_Z_RST));
      home_latched_r  <= 1'b0;
      cnt_r           <= '0;
      offboard_sent_r <= 1'b0;
      arm_sent_r      <= 1'b0;
      hold_count_r    <= '0;
      hold_active_r   <= 1'b0;
    end else if (step) begin
      phase_r         <= phase_nxt;
      home_x_r        <= home_x_l;
      home_y_r        <= home_y_l;
      out_x_r         <= out_x_l;
      out_y_r         <= out_y_l;
      cmd_x_r         <= cmd_x_nxt;
      cmd_y_r         <= cmd_y_nxt;
      cmd_z_r         <= cmd_z_nxt;
      home_latched_r  <= home_latched_r || healthy;
      cnt_r           <= cnt_nxt;
      offboard_sent_r <= off_sent_now;
      arm_sent_r      <= arm_sent_r || req_arm;
      hold_count_r    <= hold_count_nxt;
      hold_active_r   <= hold_active_nxt;
    end
  end

  assign res.setpoint_x       = cmd_x_nxt;
  assign res.setpoint_y       = cmd_y_nxt;
  assign res.setpoint_z       = cmd_z_nxt;
  assign res.setpoint_valid   = healthy;
  assign res.request_offboard = req_off;
  assign res.request_arm      = req_arm;
  assign res.mission_phase    = phase_nxt;

endmodule

>>> sv/ossc_checker.sv
module ossc_checker
  import ossc_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [POS_W-1:0] out_setpoint_x,
  input logic signed [POS_W-1:0] out_setpoint_y,
  input logic signed [POS_W-1:0] out_setpoint_z,
  input logic                    out_setpoint_valid,
  input logic                    out_request_offboard,
  input logic                    out_request_arm,
  input logic [PHASE_W-1:0]      out_mission_phase
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_setpoint_x) &&
    $stable(out_setpoint_y) && $stable(out_setpoint_z) && $stable(out_setpoint_valid) &&
    $stable(out_request_offboard) && $stable(out_request_arm) && $stable(out_mission_phase))
    else $error("stalled result changed");

  // Reset empties both stages
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // Input stalls only behind a full, stalled result stage
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // No command request on an unhealthy tick
  a_req_healthy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_setpoint_valid |-> !out_request_offboard && !out_request_arm)
    else $error("request raised on unhealthy tick");

endmodule

bind out_and_back_setpoint_sequencer_core ossc_checker u_ossc_checker (.*);

>>> sim/out_and_back_setpoint_sequencer_core_tb.sv
`timescale 1ns / 100ps

module out_and_back_setpoint_sequencer_core_tb;
  import ossc_pkg::*;

  // Run shape: a short directed opening, then segments of random ticks.
  // A register bank is written between segments.
  localparam int  SEG_COUNT   = 8;
  localparam int  SEG_TICKS   = 160;
  localparam int  QUIET_SEG   = 6;       // segments from here on run without idling
  localparam int  HOLDOFF_SEG = 3;       // segment that carries the long receiver hold-off
  localparam int  HOLDOFF_LEN = 60;
  localparam int  CYCLE_LIMIT = 200000;
  localparam int  PRINT_LIMIT = 40;
  localparam longint POS_HI   = (longint'(1) << (POS_W - 1)) - 1;
  localparam longint POS_LO   = -POS_HI - 1;

  logic                    clk;
  logic                    rst_n = 1'b0;

  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [POS_W-1:0] in_pos_x = '0;
  logic signed [POS_W-1:0] in_pos_y = '0;
  logic signed [POS_W-1:0] in_pos_z = '0;
  logic                    in_position_healthy = 1'b0;
  logic                    in_status_known = 1'b0;
  logic                    in_in_offboard = 1'b0;
  logic                    in_is_armed = 1'b0;

  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [POS_W-1:0] out_setpoint_x;
  logic signed [POS_W-1:0] out_setpoint_y;
  logic signed [POS_W-1:0] out_setpoint_z;
  logic                    out_setpoint_valid;
  logic                    out_request_offboard;
  logic                    out_request_arm;
  logic [PHASE_W-1:0]      out_mission_phase;

  logic                    cfg_psel = 1'b0;
  logic                    cfg_penable = 1'b0;
  logic                    cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]       cfg_paddr = '0;
  logic [CFG_DW-1:0]       cfg_pwdata = '0;
  logic [CFG_DW-1:0]       cfg_prdata;
  logic                    cfg_pready;

  out_and_back_setpoint_sequencer_core u_top (.*);

  // Shadow copy of the sequencer: configuration and mission state
  cfg_t                    cur_cfg;
  phase_t                  seq_phase;
  logic signed [POS_W-1:0] home_x, home_y, outp_x, outp_y;
  logic signed [POS_W-1:0] cmd_x, cmd_y, cmd_z;
  logic                    home_latched, off_sent, arm_sent, hold_on;
  logic [CNT_W-1:0]        healthy_cnt;
  logic [HOLD_W-1:0]       hold_cnt;

  in_item_t  tick_queue[$];          // ticks waiting to be offered
  out_item_t pending_setpoints[$];   // predicted results, oldest first
  in_item_t  cur_tick;

  int  mismatches = 0;
  int  ticks_taken = 0;
  int  results_seen = 0;
  int  reg_writes = 0;
  int  offboard_reqs = 0;
  int  arm_reqs = 0;
  int  cycles = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  holdoff_left = 0;
  bit  holdoff_arm = 1'b0;
  bit  holdoff_done = 1'b0;
  bit  idle_en = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp_l(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic signed [POS_W-1:0] to_pos(longint v);
    return v[POS_W-1:0];
  endfunction

  function automatic void reset_shadow();
    cur_cfg.target_height = TH_W'(TH_RST);
    cur_cfg.out_offset_x  = OFS_W'(OFSX_RST);
    cur_cfg.out_offset_y  = OFS_W'(OFSY_RST);
    cur_cfg.xy_step       = STEP_W'(STEP_RST);
    cur_cfg.z_step        = STEP_W'(STEP_RST);
    cur_cfg.reach_radius  = RAD_W'(RAD_RST);
    cur_cfg.hold_ticks    = HOLD_W'(HOLD_RST);
    cur_cfg.mode_flags    = FLAG_W'(FLAG_RST);
    seq_phase    = PH_WAIT;
    home_x       = '0;
    home_y       = '0;
    outp_x       = '0;
    outp_y       = '0;
    cmd_x        = '0;
    cmd_y        = '0;
    cmd_z        = to_pos(CMD_Z_RST);
    home_latched = 1'b0;
    off_sent     = 1'b0;
    arm_sent     = 1'b0;
    hold_on      = 1'b0;
    healthy_cnt  = '0;
    hold_cnt     = '0;
  endfunction

  // Saturate a raw register write into the shadow configuration
  function automatic void apply_register(reg_idx_t idx, logic [CFG_DW-1:0] raw);
    case (idx)
      REG_TARGET_HEIGHT:
        cur_cfg.target_height = TH_W'(clamp_l(raw[TH_W-1:0], TH_MIN, TH_MAX));
      REG_OUT_OFFSET_X:
        cur_cfg.out_offset_x = OFS_W'(clamp_l($signed(raw[OFS_W-1:0]), OFS_MIN, OFS_MAX));
      REG_OUT_OFFSET_Y:
        cur_cfg.out_offset_y = OFS_W'(clamp_l($signed(raw[OFS_W-1:0]), OFS_MIN, OFS_MAX));
      REG_XY_STEP:
        cur_cfg.xy_step = STEP_W'(clamp_l(raw[STEP_W-1:0], STEP_MIN, STEP_MAX));
      REG_Z_STEP:
        cur_cfg.z_step = STEP_W'(clamp_l(raw[STEP_W-1:0], STEP_MIN, STEP_MAX));
      REG_REACH_RADIUS:
        cur_cfg.reach_radius = RAD_W'(clamp_l(raw[RAD_W-1:0], RAD_MIN, RAD_MAX));
      REG_HOLD_TICKS:
        cur_cfg.hold_ticks = HOLD_W'(clamp_l(raw[HOLD_W-1:0], HOLD_MIN, HOLD_MAX));
      REG_MODE_FLAGS:    cur_cfg.mode_flags = raw[FLAG_W-1:0];
      default: ;
    endcase
  endfunction

  // Move one axis towards its goal by at most one step
  function automatic logic signed [POS_W-1:0] step_axis(logic signed [POS_W-1:0] cur,
                                                         logic signed [POS_W-1:0] tgt,
                                                         logic [STEP_W-1:0] step);
    longint d, s;
    d = longint'(tgt) - longint'(cur);
    s = longint'(step);
    if (d <= s && d >= -s) return tgt;
    return (d > 0) ? to_pos(longint'(cur) + s) : to_pos(longint'(cur) - s);
  endfunction

  // Arrival: per-axis bound first, then squared distance against squared radius
  function automatic bit arrived(in_item_t t, logic signed [POS_W-1:0] tx,
                                 logic signed [POS_W-1:0] ty, longint tz);
    longint r, dx, dy, dz;
    r  = longint'(cur_cfg.reach_radius);
    dx = longint'($signed(t.pos_x)) - longint'(tx);
    dy = longint'($signed(t.pos_y)) - longint'(ty);
    dz = longint'($signed(t.pos_z)) - tz;
    if (dx > r || dx < -r || dy > r || dy < -r || dz > r || dz < -r) return 1'b0;
    return (dx * dx + dy * dy + dz * dz) <= r * r;
  endfunction

  function automatic void fly_to(logic signed [POS_W-1:0] tx, logic signed [POS_W-1:0] ty,
                                 longint tz, in_item_t t, phase_t next);
    cmd_x = step_axis(cmd_x, tx, cur_cfg.xy_step);
    cmd_y = step_axis(cmd_y, ty, cur_cfg.xy_step);
    cmd_z = step_axis(cmd_z, to_pos(tz), cur_cfg.z_step);
    if (arrived(t, tx, ty, tz)) begin
      cmd_x     = tx;
      cmd_y     = ty;
      cmd_z     = to_pos(tz);
      hold_cnt  = '0;
      hold_on   = 1'b1;
      seq_phase = next;
    end
  endfunction

  function automatic void hold_point(logic signed [POS_W-1:0] tx, logic signed [POS_W-1:0] ty,
                                     longint tz, phase_t next);
    cmd_x = tx;
    cmd_y = ty;
    cmd_z = to_pos(tz);
    if (hold_on && hold_cnt >= cur_cfg.hold_ticks) begin
      hold_on   = 1'b0;
      seq_phase = next;
    end
  endfunction

  // Advance the shadow sequencer by one tick and return the setpoint it publishes
  function automatic out_item_t advance_sequencer(in_item_t t);
    out_item_t o;
    longint    tz;
    bit        ready, req_off, req_arm;
    req_off = 1'b0;
    req_arm = 1'b0;
    // Hold time runs on every tick, healthy or not
    if (hold_on && hold_cnt < 8'd255) hold_cnt++;
    if (t.position_healthy) begin
      tz = -longint'(cur_cfg.target_height);
      if (!home_latched) begin
        home_x       = t.pos_x;
        home_y       = t.pos_y;
        outp_x       = to_pos(clamp_l(longint'($signed(t.pos_x)) +
                                      longint'($signed(cur_cfg.out_offset_x)), POS_LO, POS_HI));
        outp_y       = to_pos(clamp_l(longint'($signed(t.pos_y)) +
                                      longint'($signed(cur_cfg.out_offset_y)), POS_LO, POS_HI));
        cmd_x        = t.pos_x;
        cmd_y        = t.pos_y;
        cmd_z        = to_pos(tz);
        home_latched = 1'b1;
      end
      if (healthy_cnt < CNT_SAT) healthy_cnt++;
      if (cur_cfg.mode_flags[FLAG_AUTO_OFF] && !off_sent && healthy_cnt > OFF_AFTER) begin
        req_off  = 1'b1;
        off_sent = 1'b1;
      end
      // The arm request may follow the set-mode request within the same tick
      if (cur_cfg.mode_flags[FLAG_AUTO_ARM] && off_sent && !arm_sent &&
          healthy_cnt > ARM_AFTER) begin
        req_arm  = 1'b1;
        arm_sent = 1'b1;
      end
      ready = t.status_known && (!cur_cfg.mode_flags[FLAG_REQ_OFF] || t.in_offboard) &&
              (!cur_cfg.mode_flags[FLAG_REQ_ARM] || t.is_armed);
      if (ready) begin
        case (seq_phase)
          PH_WAIT:      seq_phase = PH_GO_OUT;
          PH_GO_OUT:    fly_to(outp_x, outp_y, tz, t, PH_HOLD_OUT);
          PH_HOLD_OUT:  hold_point(outp_x, outp_y, tz, PH_RETURN);
          PH_RETURN:    fly_to(home_x, home_y, tz, t, PH_HOLD_HOME);
          PH_HOLD_HOME: hold_point(home_x, home_y, tz, PH_DONE);
          default: begin
            hold_point(home_x, home_y, tz, PH_DONE);
            seq_phase = PH_DONE;
          end
        endcase
      end
    end
    o.setpoint_x       = cmd_x;
    o.setpoint_y       = cmd_y;
    o.setpoint_z       = cmd_z;
    o.setpoint_valid   = t.position_healthy;
    o.request_offboard = req_off;
    o.request_arm      = req_arm;
    o.mission_phase    = seq_phase;
    return o;
  endfunction

  function automatic longint jitter(longint n);
    return longint'($urandom_range(0, 2 * n)) - n;
  endfunction

  // Build one tick: mostly a vehicle that tracks the commanded setpoint,
  // now and then one sitting on the goal, far off, or anywhere at all
  function automatic in_item_t compose_tick();
    in_item_t t;
    int       pick;
    longint   bx, by, bz, n;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      t.pos_x = POS_W'($urandom);
      t.pos_y = POS_W'($urandom);
      t.pos_z = POS_W'($urandom);
    end else begin
      if (pick < 20) begin
        if (seq_phase == PH_GO_OUT || seq_phase == PH_HOLD_OUT) begin
          bx = longint'(outp_x);
          by = longint'(outp_y);
        end else begin
          bx = longint'(home_x);
          by = longint'(home_y);
        end
        bz = -longint'(cur_cfg.target_height);
        n  = 0;
      end else begin
        bx = longint'(cmd_x);
        by = longint'(cmd_y);
        bz = longint'(cmd_z);
        n  = (pick < 30) ? 3000 : 250;
      end
      t.pos_x = to_pos(clamp_l(bx + jitter(n), POS_LO, POS_HI));
      t.pos_y = to_pos(clamp_l(by + jitter(n), POS_LO, POS_HI));
      t.pos_z = to_pos(clamp_l(bz + jitter(n), POS_LO, POS_HI));
    end
    t.position_healthy = ($urandom_range(0, 9) != 0);
    t.status_known     = ($urandom_range(0, 19) != 0);
    t.in_offboard      = ($urandom_range(0, 11) != 0);
    t.is_armed         = ($urandom_range(0, 11) != 0);
    return t;
  endfunction

  function automatic void push_tick(longint x, longint y, longint z,
                                    bit h, bit k, bit o, bit a);
    in_item_t t;
    t.pos_x            = to_pos(x);
    t.pos_y            = to_pos(y);
    t.pos_z            = to_pos(z);
    t.position_healthy = h;
    t.status_known     = k;
    t.in_offboard      = o;
    t.is_armed         = a;
    tick_queue.push_back(t);
  endfunction

  // Raw extremes for each register: lowest or highest value its written field holds
  function automatic logic [CFG_DW-1:0] extreme_raw(reg_idx_t idx, bit top);
    case (idx)
      REG_OUT_OFFSET_X, REG_OUT_OFFSET_Y: return top ? 32'h0000_1FFF : 32'hFFFF_E000;
      default:                            return top ? 32'hFFFF_FFFF : 32'h0000_0000;
    endcase
  endfunction

  function automatic logic [CFG_DW-1:0] random_raw(reg_idx_t idx);
    int v;
    if ($urandom_range(0, 3) == 0) return $urandom;
    case (idx)
      REG_TARGET_HEIGHT: v = $urandom_range(TH_MIN, TH_MAX);
      REG_OUT_OFFSET_X,
      REG_OUT_OFFSET_Y:  v = int'($urandom_range(0, OFS_MAX - OFS_MIN)) + OFS_MIN;
      REG_XY_STEP,
      REG_Z_STEP:        v = $urandom_range(STEP_MIN, STEP_MAX);
      REG_REACH_RADIUS:  v = $urandom_range(RAD_MIN, RAD_MAX);
      REG_HOLD_TICKS:    v = $urandom_range(HOLD_MIN, 60);
      default:           v = $urandom_range(0, 15);
    endcase
    return v;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatches < PRINT_LIMIT)
      $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Register write: setup phase, then access phase, committed while pready is high
  task automatic cfg_write(reg_idx_t idx, logic [CFG_DW-1:0] raw);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= raw;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    apply_register(idx, raw);
    reg_writes++;
    @(negedge clk);
  endtask

  // Hold off until every offered tick is taken and every setpoint is back,
  // then let the pipeline settle
  task automatic wait_drained();
    while (tick_queue.size() != 0 || in_valid || pending_setpoints.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Sender: offer queued ticks, with random idle gaps between them
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_setpoints.push_back(advance_sequencer(cur_tick));
        ticks_taken++;
        if (idle_en && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 6);
      end
      // Advance only when the current request has gone or nothing is offered
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (tick_queue.size() != 0) begin
          cur_tick = tick_queue.pop_front();
          in_pos_x            <= cur_tick.pos_x;
          in_pos_y            <= cur_tick.pos_y;
          in_pos_z            <= cur_tick.pos_z;
          in_position_healthy <= cur_tick.position_healthy;
          in_status_known     <= cur_tick.status_known;
          in_in_offboard      <= cur_tick.in_offboard;
          in_is_armed         <= cur_tick.is_armed;
          in_valid            <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off to back the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (holdoff_left > 0) begin
      out_stall <= 1'b1;
      holdoff_left--;
      if (holdoff_left == 0) holdoff_done = 1'b1;
    end else if (holdoff_arm) begin
      holdoff_arm  = 1'b0;
      holdoff_left = HOLDOFF_LEN - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Checker: compare every returned setpoint with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_request_offboard) offboard_reqs++;
      if (out_request_arm) arm_reqs++;
      if (pending_setpoints.size() == 0) begin
        report_mismatch("result with nothing pending", results_seen, 0);
      end else begin
        want = pending_setpoints.pop_front();
        if (out_setpoint_x !== want.setpoint_x)
          report_mismatch("setpoint_x", out_setpoint_x, $signed(want.setpoint_x));
        if (out_setpoint_y !== want.setpoint_y)
          report_mismatch("setpoint_y", out_setpoint_y, $signed(want.setpoint_y));
        if (out_setpoint_z !== want.setpoint_z)
          report_mismatch("setpoint_z", out_setpoint_z, $signed(want.setpoint_z));
        if (out_setpoint_valid !== want.setpoint_valid)
          report_mismatch("setpoint_valid", out_setpoint_valid, want.setpoint_valid);
        if (out_request_offboard !== want.request_offboard)
          report_mismatch("request_offboard", out_request_offboard, want.request_offboard);
        if (out_request_arm !== want.request_arm)
          report_mismatch("request_arm", out_request_arm, want.request_arm);
        if (out_mission_phase !== want.mission_phase)
          report_mismatch("mission_phase", out_mission_phase, want.mission_phase);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d setpoints outstanding",
               cycles, pending_setpoints.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    reset_shadow();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Offsets that push the out point past the top of the x range;
    // the x write itself is out of range and saturates
    cfg_write(REG_OUT_OFFSET_X, 32'd7000);
    cfg_write(REG_OUT_OFFSET_Y, -32'sd5000);

    // Directed opening (armed and offboard both required at reset)
    push_tick(POS_HI, POS_HI, POS_HI, 1'b0, 1'b1, 1'b1, 1'b1);   // unhealthy, held setpoint
    push_tick(POS_LO, POS_LO, POS_LO, 1'b0, 1'b0, 1'b0, 1'b0);
    push_tick(POS_HI - 1200, 0, -3000, 1'b1, 1'b0, 1'b1, 1'b1);  // latch home, status unknown
    push_tick(POS_HI - 1200, 0, -3000, 1'b1, 1'b1, 1'b0, 1'b1);  // not offboard
    push_tick(POS_HI - 1200, 0, -3000, 1'b1, 1'b1, 1'b1, 1'b0);  // not armed
    push_tick(POS_HI - 1200, 0, -3000, 1'b1, 1'b1, 1'b1, 1'b1);  // leave wait, no step yet
    push_tick(POS_LO, POS_LO, POS_LO, 1'b0, 1'b1, 1'b1, 1'b1);   // unhealthy mid-flight
    push_tick(POS_HI, POS_HI, POS_HI, 1'b1, 1'b1, 1'b1, 1'b1);   // far away: step only
    push_tick(POS_LO, POS_LO, POS_LO, 1'b1, 1'b1, 1'b1, 1'b1);
    push_tick(POS_HI, -5000, -3000, 1'b1, 1'b1, 1'b1, 1'b1);     // on the out point: arrive
    push_tick(0, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0);                  // unhealthy tick still counts
    push_tick(POS_HI, -5000, -3000, 1'b1, 1'b1, 1'b1, 1'b1);
    wait_drained();

    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      // Reconfigure only with the block drained: lows, then highs, then random
      if (seg > 0) begin
        for (int i = 0; i <= REG_MODE_FLAGS; i++) begin
          if (seg == 1)      cfg_write(reg_idx_t'(i), extreme_raw(reg_idx_t'(i), 1'b0));
          else if (seg == 2) cfg_write(reg_idx_t'(i), extreme_raw(reg_idx_t'(i), 1'b1));
          else               cfg_write(reg_idx_t'(i), random_raw(reg_idx_t'(i)));
        end
      end
      idle_en = (seg < QUIET_SEG) && (seg != 4);
      for (int n = 0; n < SEG_TICKS; n++) begin
        while (tick_queue.size() >= 2) @(negedge clk);
        tick_queue.push_back(compose_tick());
        if (seg == HOLDOFF_SEG && n == 40) holdoff_arm = 1'b1;
      end
      wait_drained();
    end

    $display("Covered %0d ticks and %0d setpoints across %0d register writes",
             ticks_taken, results_seen, reg_writes);
    $display("Mission ended in %s; set-mode requests %0d, arm requests %0d, hold-off %0s",
             seq_phase.name(), offboard_reqs, arm_reqs, holdoff_done ? "done" : "missed");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> files.f
sv/ossc_pkg.sv
sv/ossc_cfg.sv
sv/ossc_reach.sv
sv/ossc_seq.sv
sv/out_and_back_setpoint_sequencer_core.sv
sv/ossc_checker.sv
sim/out_and_back_setpoint_sequencer_core_tb.sv
